### rtl/mi3_pkg.sv
// Shared constants for the 3x3 matrix inverse block.
`default_nettype none
package mi3_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int THR_WIDTH      = 31;
   localparam int NUM_ELEM       = 9;
   localparam int COF_LAT        = 2;
   localparam int DET_LAT        = 3;
endpackage
`default_nettype wire

### rtl/mi3_if.sv
// Valid/ready channel interfaces for matrix transactions and result transactions.
`default_nettype none
interface mi3_req_if #(parameter int DW = mi3_pkg::DATA_WIDTH_DEF);
   logic valid;
   logic ready;
   logic signed [DW-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
   modport source (output valid, m00, m10, m20, m01, m11, m21, m02, m12, m22, input ready);
   modport sink   (input valid, m00, m10, m20, m01, m11, m21, m02, m12, m22, output ready);
endinterface

interface mi3_rsp_if #(parameter int DW = mi3_pkg::DATA_WIDTH_DEF);
   logic valid;
   logic ready;
   logic signed [DW-1:0] inv00, inv10, inv20, inv01, inv11, inv21, inv02, inv12, inv22;
   logic signed [DW-1:0] det;
   logic singular;
   modport source (output valid, inv00, inv10, inv20, inv01, inv11, inv21, inv02, inv12,
                   inv22, det, singular, input ready);
   modport sink   (input valid, inv00, inv10, inv20, inv01, inv11, inv21, inv02, inv12,
                   inv22, det, singular, output ready);
endinterface
`default_nettype wire

### rtl/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse: cofactor lanes, determinant merge, divider lanes.
//
// Usage:
//  - req_ch carries one matrix per transaction (nine signed fixed-point entries,
//    column-major). rsp_ch returns one result per transaction: the nine inverse
//    entries, the rounded determinant and the singular flag, in input order.
//  - csr_we/csr_wdata write the singular threshold (unsigned, same scaling as
//    the entries). Write it only while no transaction is in flight.
//  - Throughput: one matrix per cycle, sustained while req_ch.ready stays high.
//  - Pipeline stages: input register 1, cofactor multipliers 2, determinant
//    merge 3, then in each divider lane: form the rounded dividend, range
//    check, one quotient bit per stage, saturate.
//  - Nine cofactor lanes and nine divider lanes run side by side; the merge
//    stage combines the first-row cofactors into the determinant.
//  - Stall: the result register is backed by one skid entry, so a matrix is
//    still accepted while a finished result waits. The pipeline holds only
//    once the skid entry is occupied; req_ch.ready then drops.
//  - Reset (synchronous): clears all valid flags and the threshold to zero.
`default_nettype none
module matrix3x3_inverse #(
   parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   mi3_req_if.sink                       req_ch,
   mi3_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [mi3_pkg::THR_WIDTH-1:0] csr_wdata
);
   import mi3_pkg::*;

   localparam int DW   = DATA_WIDTH;
   localparam int CW   = 2*DW + 1;
   localparam int MW   = 3*DW + 3;
   localparam int DLAT = DW + 3;
   localparam int LAT  = 1 + COF_LAT + DET_LAT + DLAT;

   // operand selection per cofactor lane: c = a[x]*a[y] - a[u]*a[v]
   localparam int CSEL [NUM_ELEM][4] = '{
      '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
      '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
      '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}};

   typedef struct packed {
      logic [NUM_ELEM-1:0][DW-1:0] inv;
      logic [DW-1:0]               det;
      logic                        sing;
   } res_type;

   logic                 en;
   logic [THR_WIDTH-1:0] thr_ff;
   logic [LAT-1:0]       v_ff;
   logic signed [DW-1:0] a_ff [NUM_ELEM];
   logic signed [CW-1:0] cof  [NUM_ELEM];

   res_type out_ff, out_in, skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic    last_v;

   // global advance: hold everything only while the skid entry is full
   assign en           = !skid_valid_ff;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= req_ch.m00;
         a_ff[1] <= req_ch.m10;
         a_ff[2] <= req_ch.m20;
         a_ff[3] <= req_ch.m01;
         a_ff[4] <= req_ch.m11;
         a_ff[5] <= req_ch.m21;
         a_ff[6] <= req_ch.m02;
         a_ff[7] <= req_ch.m12;
         a_ff[8] <= req_ch.m22;
      end
   end

   for (genvar k = 0; k < NUM_ELEM; k++) begin : g_cof
      mi3_cof #(.DW(DW)) u_cof (
         .clock (clock),
         .en    (en),
         .x     (a_ff[CSEL[k][0]]),
         .y     (a_ff[CSEL[k][1]]),
         .u     (a_ff[CSEL[k][2]]),
         .v     (a_ff[CSEL[k][3]]),
         .cof   (cof[k])
      );
   end

   // first-row entries, delayed to meet the cofactors
   logic signed [DW-1:0] row_ff [COF_LAT][3];
   logic signed [DW-1:0] row    [3];
   logic signed [CW-1:0] cof0   [3];

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff[0][0] <= a_ff[0];
         row_ff[0][1] <= a_ff[3];
         row_ff[0][2] <= a_ff[6];
         for (int s = 1; s < COF_LAT; s++) begin
            row_ff[s] <= row_ff[s-1];
         end
      end
   end

   assign row  = row_ff[COF_LAT-1];
   assign cof0 = '{cof[0], cof[1], cof[2]};

   logic [MW-1:0] det_mag;
   logic          det_neg, sing;
   logic [DW-1:0] det_word;

   mi3_det #(.DW(DW), .FB(FRAC_BITS)) u_det (
      .clock    (clock),
      .en       (en),
      .a        (row),
      .c        (cof0),
      .thr      (thr_ff),
      .det_mag  (det_mag),
      .det_neg  (det_neg),
      .sing     (sing),
      .det_word (det_word)
   );

   // cofactors wait for the determinant
   logic signed [CW-1:0] cd_ff [DET_LAT][NUM_ELEM];

   always_ff @(posedge clock) begin
      if (en) begin
         cd_ff[0] <= cof;
         for (int s = 1; s < DET_LAT; s++) begin
            cd_ff[s] <= cd_ff[s-1];
         end
      end
   end

   logic [NUM_ELEM-1:0][DW-1:0] inv;

   for (genvar k = 0; k < NUM_ELEM; k++) begin : g_div
      mi3_div #(.DW(DW), .FB(FRAC_BITS)) u_div (
         .clock   (clock),
         .en      (en),
         .cof     (cd_ff[DET_LAT-1][k]),
         .det_mag (det_mag),
         .det_neg (det_neg),
         .sing    (sing),
         .inv     (inv[k])
      );
   end

   // determinant word and flag ride alongside the divider lanes
   logic [DW-1:0] dw_ff [DLAT];
   logic          sg_ff [DLAT];

   always_ff @(posedge clock) begin
      if (en) begin
         dw_ff[0] <= det_word;
         sg_ff[0] <= sing;
         for (int s = 1; s < DLAT; s++) begin
            dw_ff[s] <= dw_ff[s-1];
            sg_ff[s] <= sg_ff[s-1];
         end
      end
   end

   res_type pipe_res;
   assign pipe_res.inv  = inv;
   assign pipe_res.det  = dw_ff[DLAT-1];
   assign pipe_res.sing = sg_ff[DLAT-1];

   // output register plus one skid entry
   assign last_v = v_ff[LAT-1];

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (en) begin
         if (!out_valid_ff || rsp_ch.ready) begin
            // advance the finished transaction straight to the output
            out_valid_in = last_v;
            out_in       = pipe_res;
         end else begin
            // receiver stalled: park the finished transaction
            skid_valid_in = last_v;
            skid_in       = pipe_res;
         end
      end else if (rsp_ch.ready) begin
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.inv00    = out_ff.inv[0];
   assign rsp_ch.inv10    = out_ff.inv[1];
   assign rsp_ch.inv20    = out_ff.inv[2];
   assign rsp_ch.inv01    = out_ff.inv[3];
   assign rsp_ch.inv11    = out_ff.inv[4];
   assign rsp_ch.inv21    = out_ff.inv[5];
   assign rsp_ch.inv02    = out_ff.inv[6];
   assign rsp_ch.inv12    = out_ff.inv[7];
   assign rsp_ch.inv22    = out_ff.inv[8];
   assign rsp_ch.det      = out_ff.det;
   assign rsp_ch.singular = out_ff.sing;
endmodule
`default_nettype wire

### rtl/mi3_cof.sv
// One cofactor lane: x*y - u*v, two registered stages.
`default_nettype none
module mi3_cof #(
   parameter int DW = mi3_pkg::DATA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [DW-1:0] x,
   input  logic signed [DW-1:0] y,
   input  logic signed [DW-1:0] u,
   input  logic signed [DW-1:0] v,
   output logic signed [2*DW:0] cof
);
   import mi3_pkg::*;

   logic signed [2*DW-1:0] p_ff, q_ff;
   logic signed [2*DW:0]   c_ff, c_in;

   assign c_in = (2*DW+1)'(p_ff) - (2*DW+1)'(q_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= x * y;
         q_ff <= u * v;
         c_ff <= c_in;
      end
   end

   assign cof = c_ff;
endmodule
`default_nettype wire

### rtl/mi3_det.sv
// Merge stage: determinant from first-row cofactors, singular test, rounded determinant.
`default_nettype none
module mi3_det #(
   parameter int DW = mi3_pkg::DATA_WIDTH_DEF,
   parameter int FB = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [DW-1:0]             a   [3],
   input  logic signed [2*DW:0]             c   [3],
   input  logic [mi3_pkg::THR_WIDTH-1:0]    thr,
   output logic [3*DW+2:0]                  det_mag,
   output logic                             det_neg,
   output logic                             sing,
   output logic [DW-1:0]                    det_word
);
   import mi3_pkg::*;

   localparam int CW = 2*DW + 1;
   localparam int MW = 3*DW + 3;
   localparam int EW = MW + THR_WIDTH + 2*FB;
   localparam logic [MW:0] HALF    = ((MW+1)'(1) << (2*FB)) >> 1;
   localparam logic [MW:0] LIM_NEG = (MW+1)'(1) << (DW-1);
   localparam logic [MW:0] LIM_POS = LIM_NEG - (MW+1)'(1);

   logic signed [CW-1:0] plo_ff [3];
   logic signed [CW-1:0] phi_ff [3];
   logic signed [MW-1:0] sum_ff, sum_in;
   logic [MW-1:0]        mag;
   logic [MW:0]          rnd, lim, satm;
   logic                 neg;
   logic [MW-1:0]        mag_ff;
   logic                 neg_ff, sing_ff;
   logic [DW-1:0]        word_ff, word_in;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < 3; k++) begin
         sum_in = sum_in + (MW'(phi_ff[k]) <<< DW) + MW'(plo_ff[k]);
      end
   end

   assign neg  = sum_ff[MW-1];
   assign mag  = neg ? MW'(-sum_ff) : MW'(sum_ff);
   assign rnd  = ((MW+1)'(mag) + HALF) >> (2*FB);
   assign lim  = neg ? LIM_NEG : LIM_POS;
   assign satm = (rnd > lim) ? lim : rnd;
   assign word_in = neg ? DW'(-satm) : DW'(satm);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            plo_ff[k] <= CW'(a[k] * $signed({1'b0, c[k][DW-1:0]}));
            phi_ff[k] <= CW'(a[k] * $signed(c[k][CW-1:DW]));
         end
         sum_ff  <= sum_in;
         mag_ff  <= mag;
         neg_ff  <= neg;
         sing_ff <= EW'(mag) <= (EW'(thr) << (2*FB));
         word_ff <= word_in;
      end
   end

   assign det_mag  = mag_ff;
   assign det_neg  = neg_ff;
   assign sing     = sing_ff;
   assign det_word = word_ff;
endmodule
`default_nettype wire

### rtl/mi3_div.sv
// One divider lane: rounded cofactor/determinant quotient, one bit per stage, saturated, zero if singular.
`default_nettype none
module mi3_div #(
   parameter int DW = mi3_pkg::DATA_WIDTH_DEF,
   parameter int FB = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [2*DW:0] cof,
   input  logic [3*DW+2:0]      det_mag,
   input  logic                 det_neg,
   input  logic                 sing,
   output logic [DW-1:0]        inv
);
   import mi3_pkg::*;

   localparam int CW = 2*DW + 1;
   localparam int MW = 3*DW + 3;
   localparam int QW = DW;
   localparam int NA = ((CW + 2*FB + 1 > MW) ? CW + 2*FB + 1 : MW) + 1;
   localparam int NB = MW + 1 + QW;
   localparam int WW = (NA > NB) ? NA : NB;
   localparam logic [DW:0] LIM_NEG = (DW+1)'(1) << (DW-1);
   localparam logic [DW:0] LIM_POS = LIM_NEG - (DW+1)'(1);

   logic [CW-1:0] cmag;
   logic [WW-1:0] n_ff, dd_ff;
   logic          fneg_ff, fsing_ff;

   logic [WW-1:0] rem_ff [QW+1];
   logic [WW-1:0] d_ff   [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic          ovf_ff [QW+1];
   logic          neg_ff [QW+1];
   logic          sg_ff  [QW+1];

   logic [DW:0]   mag, lim, satm;
   logic [DW-1:0] inv_ff, inv_in;

   assign cmag = cof[CW-1] ? CW'(-cof) : CW'(cof);

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff     <= (WW'(cmag) << (2*FB+1)) + WW'(det_mag);
         dd_ff    <= WW'(det_mag) << 1;
         fneg_ff  <= cof[CW-1] ^ det_neg;
         fsing_ff <= sing;
         rem_ff[0] <= n_ff;
         d_ff[0]   <= dd_ff;
         q_ff[0]   <= '0;
         ovf_ff[0] <= n_ff >= (dd_ff << QW);
         neg_ff[0] <= fneg_ff;
         sg_ff[0]  <= fsing_ff;
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_step
      localparam int B = QW - 1 - i;
      logic [WW-1:0] t;
      logic          take;
      assign t    = d_ff[i] << B;
      assign take = rem_ff[i] >= t;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= take ? rem_ff[i] - t : rem_ff[i];
            q_ff[i+1]   <= q_ff[i] | (take ? (QW'(1) << B) : '0);
            d_ff[i+1]   <= d_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            sg_ff[i+1]  <= sg_ff[i];
         end
      end
   end

   assign mag    = ovf_ff[QW] ? '1 : {1'b0, q_ff[QW]};
   assign lim    = neg_ff[QW] ? LIM_NEG : LIM_POS;
   assign satm   = (mag > lim) ? lim : mag;
   assign inv_in = sg_ff[QW] ? '0 : (neg_ff[QW] ? DW'(-satm) : DW'(satm));

   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff <= inv_in;
      end
   end

   assign inv = inv_ff;
endmodule
`default_nettype wire

### rtl/mi3_chk.sv
// Port-level checker for the 3x3 matrix inverse, bound to the top level.
`default_nettype none
module mi3_chk #(
   parameter int DW = mi3_pkg::DATA_WIDTH_DEF
) (
   input logic          clock,
   input logic          reset,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic          rsp_singular,
   input logic [DW-1:0] rsp_inv00, rsp_inv10, rsp_inv20,
   input logic [DW-1:0] rsp_inv01, rsp_inv11, rsp_inv21,
   input logic [DW-1:0] rsp_inv02, rsp_inv12, rsp_inv22
);
   import mi3_pkg::*;

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |->
         rsp_inv00 == '0 && rsp_inv10 == '0 && rsp_inv20 == '0 &&
         rsp_inv01 == '0 && rsp_inv11 == '0 && rsp_inv21 == '0 &&
         rsp_inv02 == '0 && rsp_inv12 == '0 && rsp_inv22 == '0)
      else $error("singular result with nonzero inverse");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input held off while no result is pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
endmodule

bind matrix3x3_inverse mi3_chk #(.DW(DATA_WIDTH)) u_mi3_chk (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_singular (rsp_ch.singular),
   .rsp_inv00    (rsp_ch.inv00),
   .rsp_inv10    (rsp_ch.inv10),
   .rsp_inv20    (rsp_ch.inv20),
   .rsp_inv01    (rsp_ch.inv01),
   .rsp_inv11    (rsp_ch.inv11),
   .rsp_inv21    (rsp_ch.inv21),
   .rsp_inv02    (rsp_ch.inv02),
   .rsp_inv12    (rsp_ch.inv12),
   .rsp_inv22    (rsp_ch.inv22)
);
`default_nettype wire
